FILE: hw/rtl/slrng_pkg.sv
package slrng_pkg;

  localparam int unsigned LEN     = 55;
  localparam int unsigned IDX_W   = 6;
  localparam int unsigned VAL_W   = 30;
  localparam int unsigned SEED_W  = 28;
  localparam int unsigned PASS_W  = 2;

  localparam logic [VAL_W-1:0]  MOD          = 30'd1000000000;
  localparam logic [SEED_W-1:0] SEED_BASE    = 28'd161803398;
  localparam logic [IDX_W-1:0]  TAB_LEN      = 6'd55;
  localparam logic [IDX_W-1:0]  SCATTER      = 6'd21;
  localparam logic [IDX_W-1:0]  MIX_OFFSET   = 6'd30;
  localparam logic [IDX_W-1:0]  LEAD_START   = 6'd0;
  localparam logic [IDX_W-1:0]  TRAIL_START  = 6'd31;
  localparam logic [PASS_W-1:0] LAST_PASS    = 2'd3;

  typedef logic [VAL_W-1:0]  val_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [SEED_W-1:0] seed_t;

  // (a - b) mod 10^9 for a and b already below the modulus.
  function automatic val_t sub_mod(val_t a, val_t b);
    logic [VAL_W:0] diff;
    logic [VAL_W:0] wrapped;
    diff    = {1'b0, a} - {1'b0, b};
    wrapped = diff + {1'b0, MOD};
    return diff[VAL_W] ? wrapped[VAL_W-1:0] : diff[VAL_W-1:0];
  endfunction

  // Table positions run 1..55 and wrap back to 1.
  function automatic idx_t idx_next(idx_t x);
    return (x >= TAB_LEN) ? idx_t'(1) : idx_t'(x + idx_t'(1));
  endfunction

endpackage

FILE: hw/rtl/slrng_ifs.sv
interface slrng_in_if;
  import slrng_pkg::*;
  logic  valid;
  logic  ready;
  logic  reseed;
  seed_t seed;
  modport source (output valid, output reseed, output seed, input ready);
  modport sink   (input valid, input reseed, input seed, output ready);
endinterface

interface slrng_out_if;
  import slrng_pkg::*;
  logic valid;
  logic ready;
  val_t value;
  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

FILE: hw/rtl/slrng_ram.sv
module slrng_ram #(
  parameter int unsigned WIDTH = 30,
  parameter int unsigned DEPTH = 55,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/subtractive_lagged_rng_unit.sv
// Channel   Port     Direction  Payload
// request   in_req   sink       reseed (1 bit), seed (28 bits)
// result    out_res  source     value (30 bits, 0..999999999)
//
// A plain draw presents both table reads to the memories in the accept cycle;
// in S_DRAW_WR it then subtracts and writes the lead entry back.
// A seeding request runs through the accept cycle, 55 table fills,
// 4 x 55 mixing steps (each a read, then a write back), and the read
// and write-back cycles of the draw.
// Reset sets the indices to their start values and clears the seeded flag;
// the table holds no reset value and is always seeded before a draw uses it.
// A stalled result waits in the output register; the block holds its
// write-back until that register is free and takes no new request meanwhile.
module subtractive_lagged_rng_unit
  import slrng_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  slrng_in_if.sink    in_req,
  slrng_out_if.source out_res
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL_TOP,
    S_FILL,
    S_MIX_RD,
    S_MIX_WR,
    S_DRAW_RD,
    S_DRAW_WR
  } state_t;

  state_t          state_r, state_nxt;
  val_t            prev_r, prev_nxt;
  val_t            cur_r, cur_nxt;
  idx_t            pos_r, pos_nxt;     // fill scatter position, then mixing index
  idx_t            cnt_r, cnt_nxt;     // fill step count
  logic [PASS_W-1:0] pass_r, pass_nxt;
  idx_t            lead_r, lead_nxt;
  idx_t            trail_r, trail_nxt;
  logic            seeded_r, seeded_nxt;
  logic            out_valid_r, out_valid_nxt;
  val_t            out_value_r, out_value_nxt;

  // Both memories hold the same table, so both reads of a pair are served in the same cycle.
  logic            we;
  idx_t            wpos;
  val_t            wdata;
  idx_t            rpos_a, rpos_b;
  val_t            rdata_a, rdata_b;
  val_t            diff;
  idx_t            mix_partner;
  logic [IDX_W:0]  pos_sum;
  logic [IDX_W:0]  partner_sum;
  seed_t           seed_sat;
  logic            in_fire;
  logic            out_free;

  assign in_req.ready  = (state_r == S_IDLE);
  assign in_fire       = in_req.valid && in_req.ready;
  assign out_free      = !out_valid_r || out_res.ready;
  assign out_res.valid = out_valid_r;
  assign out_res.value = out_value_r;

  assign seed_sat = (in_req.seed > SEED_BASE) ? SEED_BASE : in_req.seed;
  assign diff     = sub_mod(rdata_a, rdata_b);

  // Mixing partner of position i is 1 + (i + 30) mod 55.
  always_comb begin
    partner_sum = {1'b0, pos_r} + {1'b0, MIX_OFFSET};
    if (partner_sum >= {1'b0, TAB_LEN}) begin
      partner_sum = partner_sum - {1'b0, TAB_LEN};
    end
    mix_partner = partner_sum[IDX_W-1:0] + idx_t'(1);
  end

  // Read addresses: in idle the next draw's entries are fetched ahead, so a
  // plain draw has its data in the cycle after the request is taken.
  always_comb begin
    unique case (state_r)
      S_IDLE: begin
        rpos_a = idx_next(lead_r);
        rpos_b = idx_next(trail_r);
      end
      S_MIX_RD, S_MIX_WR: begin
        rpos_a = pos_r;
        rpos_b = mix_partner;
      end
      default: begin
        rpos_a = lead_r;
        rpos_b = trail_r;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    prev_nxt      = prev_r;
    cur_nxt       = cur_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    pass_nxt      = pass_r;
    lead_nxt      = lead_r;
    trail_nxt     = trail_r;
    seeded_nxt    = seeded_r;
    out_valid_nxt = out_valid_r && !out_res.ready;
    out_value_nxt = out_value_r;
    we            = 1'b0;
    wpos          = lead_r;
    wdata         = diff;
    pos_sum       = {1'b0, pos_r} + {1'b0, SCATTER};
    if (pos_sum >= {1'b0, TAB_LEN}) begin
      pos_sum = pos_sum - {1'b0, TAB_LEN};
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_req.reseed || !seeded_r) begin
            prev_nxt  = val_t'(SEED_BASE - seed_sat);
            cur_nxt   = val_t'(1);
            pos_nxt   = SCATTER;
            cnt_nxt   = idx_t'(1);
            state_nxt = S_FILL_TOP;
          end else begin
            lead_nxt  = idx_next(lead_r);
            trail_nxt = idx_next(trail_r);
            state_nxt = S_DRAW_WR;
          end
        end
      end
      S_FILL_TOP: begin
        // The last entry takes the seed difference itself.
        we        = 1'b1;
        wpos      = TAB_LEN;
        wdata     = prev_r;
        state_nxt = S_FILL;
      end
      S_FILL: begin
        we       = 1'b1;
        wpos     = pos_r;
        wdata    = cur_r;
        cur_nxt  = sub_mod(prev_r, cur_r);
        prev_nxt = cur_r;
        pos_nxt  = pos_sum[IDX_W-1:0];
        cnt_nxt  = cnt_r + idx_t'(1);
        if (cnt_r == TAB_LEN - idx_t'(1)) begin
          pos_nxt   = idx_t'(1);
          pass_nxt  = '0;
          state_nxt = S_MIX_RD;
        end
      end
      S_MIX_RD: begin
        state_nxt = S_MIX_WR;
      end
      S_MIX_WR: begin
        we        = 1'b1;
        wpos      = pos_r;
        state_nxt = S_MIX_RD;
        if (pos_r == TAB_LEN) begin
          pos_nxt = idx_t'(1);
          if (pass_r == LAST_PASS) begin
            lead_nxt   = idx_next(LEAD_START);
            trail_nxt  = idx_next(TRAIL_START);
            seeded_nxt = 1'b1;
            state_nxt  = S_DRAW_RD;
          end else begin
            pass_nxt = pass_r + 1'b1;
          end
        end else begin
          pos_nxt = pos_r + idx_t'(1);
        end
      end
      S_DRAW_RD: begin
        state_nxt = S_DRAW_WR;
      end
      S_DRAW_WR: begin
        // Write back only once the result has somewhere to go; the read
        // addresses stay put, so the fetched data holds while waiting.
        if (out_free) begin
          we            = 1'b1;
          wpos          = lead_r;
          out_valid_nxt = 1'b1;
          out_value_nxt = diff;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lead_r      <= LEAD_START;
      trail_r     <= TRAIL_START;
      seeded_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lead_r      <= lead_nxt;
      trail_r     <= trail_nxt;
      seeded_r    <= seeded_nxt;
      out_valid_r <= out_valid_nxt;
    end
    prev_r      <= prev_nxt;
    cur_r       <= cur_nxt;
    pos_r       <= pos_nxt;
    cnt_r       <= cnt_nxt;
    pass_r      <= pass_nxt;
    out_value_r <= out_value_nxt;
  end

  // Table position p lives at memory address p - 1.
  slrng_ram #(.WIDTH(VAL_W), .DEPTH(LEN)) u_ram_a (
    .clk   (clk),
    .we    (we),
    .waddr (wpos - idx_t'(1)),
    .wdata (wdata),
    .raddr (rpos_a - idx_t'(1)),
    .rdata (rdata_a)
  );

  slrng_ram #(.WIDTH(VAL_W), .DEPTH(LEN)) u_ram_b (
    .clk   (clk),
    .we    (we),
    .waddr (wpos - idx_t'(1)),
    .wdata (wdata),
    .raddr (rpos_b - idx_t'(1)),
    .rdata (rdata_b)
  );

endmodule

FILE: hw/rtl/slrng_checker.sv
module slrng_checker
  import slrng_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input val_t out_value
);

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value))
    else $error("result changed or dropped while stalled");

  // Every result lies below the modulus.
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_value < MOD)
    else $error("result not below 10^9");

  // An accepted request always makes the block busy, so ready is low once it is taken.
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after a request");

  // No result is offered right after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind subtractive_lagged_rng_unit slrng_checker u_slrng_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_req.valid),
  .in_ready  (in_req.ready),
  .out_valid (out_res.valid),
  .out_ready (out_res.ready),
  .out_value (out_res.value)
);
